### rtl/core/abmc_pkg.sv
package abmc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PRICE_W    = 32;
	localparam int RV_W       = 17;
	localparam int DISC_W     = 31;
	localparam int STEPS_W    = 13;
	localparam int PATHS_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 35;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_W = 96;
	localparam int DEN_W = PATHS_W;

	localparam int SUM_W   = 48;
	localparam int SQSUM_W = 64;

	localparam int XO_W = 34;

	localparam logic [XO_W-1:0] LN2_Q28    = 34'd186065280;
	// 24 * ln2 keeps x + offset non-negative for every sample
	localparam logic [XO_W-1:0] EXP_OFFSET = 34'd4465566720;
	localparam logic [6:0]      LN2_RECIP  = 7'd92;
	localparam int              LN2_RECIP_SH = 34;
	localparam int              KSH_BASE   = 54;
	localparam int              TAYLOR_TERMS = 13;
	localparam int              MAX_STEPS  = 4096;
	localparam int              RECIP_SH   = 34;

	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

	localparam logic [31:0] RST_START_SPOT  = 32'd6553600;
	localparam logic [31:0] RST_STRIKE      = 32'd6553600;
	localparam logic [31:0] RST_BARRIER     = 32'd7864320;
	localparam logic [31:0] RST_DRIFT       = 32'd1073741824;
	localparam logic [16:0] RST_ROOT_VAR    = 17'd819;
	localparam logic [30:0] RST_DISCOUNT    = 31'd1073741824;
	localparam logic [12:0] RST_STEPS       = 13'd256;
	localparam logic [15:0] RST_PATHS       = 16'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_SPOT,
		CFG_STRIKE,
		CFG_BARRIER,
		CFG_DRIFT,
		CFG_ROOT_VAR,
		CFG_DISCOUNT,
		CFG_STEPS,
		CFG_PATHS
	} cfg_idx_t;

	// ceil(2^34 / i): floor(a/i) = (a * recip) >> 34 for a < 2^30
	function automatic logic [MUL_B_W-1:0] taylor_recip(input logic [3:0] i);
		logic [MUL_B_W-1:0] r;
		case (i)
			4'd1:    r = 35'd17179869184;
			4'd2:    r = 35'd8589934592;
			4'd3:    r = 35'd5726623062;
			4'd4:    r = 35'd4294967296;
			4'd5:    r = 35'd3435973837;
			4'd6:    r = 35'd2863311531;
			4'd7:    r = 35'd2454267027;
			4'd8:    r = 35'd2147483648;
			4'd9:    r = 35'd1908874354;
			4'd10:   r = 35'd1717986919;
			4'd11:   r = 35'd1561806290;
			4'd12:   r = 35'd1431655766;
			4'd13:   r = 35'd1321528399;
			default: r = 35'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/abmc_if.sv
interface abmc_in_if;
	logic valid;
	logic ready;
	logic signed [abmc_pkg::SAMPLE_W-1:0] gauss_sample;

	modport source(output valid, output gauss_sample, input ready);
	modport sink(input valid, input gauss_sample, output ready);
endinterface

interface abmc_out_if;
	logic valid;
	logic ready;
	logic [abmc_pkg::PRICE_W-1:0] pair_payoff;
	logic summary_valid;
	logic [abmc_pkg::PRICE_W-1:0] price_mean;
	logic [abmc_pkg::PRICE_W-1:0] std_err;
	logic sum_saturated;

	modport source(output valid, output pair_payoff, output summary_valid,
		output price_mean, output std_err, output sum_saturated, input ready);
	modport sink(input valid, input pair_payoff, input summary_valid,
		input price_mean, input std_err, input sum_saturated, output ready);
endinterface

### rtl/core/abmc_div.sv
// Restoring divider, one quotient bit per cycle; done pulses with quo valid.
module abmc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [abmc_pkg::DIV_W-1:0]     num,
	input  logic [abmc_pkg::DEN_W-1:0]     den,
	output logic                           done,
	output logic [abmc_pkg::DIV_W-1:0]     quo
);

	logic [abmc_pkg::DIV_W-1:0] quo_q;
	logic [abmc_pkg::DEN_W-1:0] rem_q;
	logic [abmc_pkg::DEN_W-1:0] den_q;
	logic [6:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [abmc_pkg::DEN_W:0]   trial;
	logic                       ge;
	logic [abmc_pkg::DEN_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, quo_q[abmc_pkg::DIV_W-1]};
		ge     = trial >= {1'b0, den_q};
		rem_nx = ge ? abmc_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[abmc_pkg::DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				quo_q <= {quo_q[abmc_pkg::DIV_W-2:0], ge};
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(abmc_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/antithetic_barrier_mc_pricer.sv
// Channel   Dir  Payload                                             Beat when
// samples   in   gauss_sample                                         valid & ready
// results   out  pair_payoff, summary_valid, price_mean, std_err,     valid & ready
//                sum_saturated
// cfg       in   cfg_index, cfg_data                                  cfg_wr_en
//
// With both legs live, each sample runs per leg a range reduction (S_LEG, S_K, S_R),
// 13 Taylor terms (S_TA, S_TB, S_TC each) and a spot update (S_D1, S_D2, S_M), all on
// one shared 32x35 multiplier; a knocked-out leg only passes S_LEG. A path end adds the
// payoff and sum states; the last path of a run adds three serial divides and a square root.
// Reset clears control state and loads register defaults. A result waits in the
// output register while the next sample is taken; only a second result stalls.
module antithetic_barrier_mc_pricer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [abmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abmc_pkg::CFG_DATA_W-1:0]     cfg_data,
	abmc_in_if.sink                             samples,
	abmc_out_if.source                          results
);

	typedef enum logic [4:0] {
		S_IDLE, S_X, S_LEG, S_K, S_R, S_TA, S_TB, S_TC, S_D1, S_D2, S_M, S_STEP,
		S_P, S_P2, S_PAIR, S_SQ, S_MEAN, S_Q1, S_Q2, S_Q3, S_QD, S_SQRT, S_SED, S_EMIT
	} state_t;

	state_t state_q;

	logic [31:0] start_spot_q, strike_q, barrier_q, drift_q;
	logic [16:0] rv_q;
	logic [30:0] disc_q;
	logic [12:0] steps_q;
	logic [15:0] paths_q;

	logic [31:0] spot_q [2];
	logic        ko_q [2];
	logic [31:0] pay_q [2];
	logic        leg_q;

	logic        g_neg_q;
	logic [32:0] xmag_q;
	logic [abmc_pkg::XO_W-1:0] xo_q;
	logic [5:0]  q_q;
	logic [29:0] r30_q;
	logic [30:0] term_q;
	logic [31:0] m_q;
	logic [3:0]  i_q;

	logic [12:0] step_q;
	logic [15:0] path_q;
	logic [abmc_pkg::SUM_W-1:0]   sum_q;
	logic [abmc_pkg::SQSUM_W-1:0] sqsum_q;
	logic        sat_q;
	logic        last_q;
	logic [31:0] pair_q;
	logic [31:0] mean_q, se_q;
	logic [abmc_pkg::DIV_W-1:0] acc_q;
	logic [63:0] isv_q, isr_q, isb_q;

	logic        div_go_q;
	logic [abmc_pkg::DIV_W-1:0] div_num_q;
	logic        div_done;
	logic [abmc_pkg::DIV_W-1:0] div_quo;

	logic [abmc_pkg::MUL_P_W-1:0] mul_q;
	logic [abmc_pkg::MUL_A_W-1:0] mul_a;
	logic [abmc_pkg::MUL_B_W-1:0] mul_b;

	logic        out_vld_q;
	logic [31:0] out_pair_q, out_mean_q, out_se_q;
	logic        out_sum_q, out_sat_q;

	// combinational helpers
	logic [16:0] gmag_c;
	logic [abmc_pkg::XO_W-1:0] xo_c;
	logic [abmc_pkg::XO_W-1:0] rem_c;
	logic        rem_ge;
	logic [27:0] r_c;
	logic        t_over;
	logic [31:0] t_c;
	logic [5:0]  sh_c;
	logic [63:0] shifted_c;
	logic [31:0] spot_new_c;
	logic        spot_over;
	logic [32:0] diff_c;
	logic        pay_zero;
	logic [32:0] pay_sum_c;
	logic [31:0] pair_c;
	logic [64:0] sq_add_c;
	logic [15:0] path_nx;
	logic [15:0] paths_eff;
	logic [12:0] steps_eff;
	logic [12:0] step_nx;
	logic [63:0] qsq_c;
	logic [63:0] d_c;
	logic [63:0] is_trial;
	logic        is_ge;
	logic [63:0] isr_nx;
	logic [abmc_pkg::DIV_W-1:0] acc_nx;

	always_comb begin
		gmag_c = samples.gauss_sample[15] ?
			17'(~{samples.gauss_sample[15], samples.gauss_sample} + 17'd1) :
			{1'b0, samples.gauss_sample};
		xo_c = (g_neg_q ^ leg_q) ? abmc_pkg::EXP_OFFSET - abmc_pkg::XO_W'(xmag_q) :
			abmc_pkg::EXP_OFFSET + abmc_pkg::XO_W'(xmag_q);
		rem_c  = xo_q - mul_q[abmc_pkg::XO_W-1:0];
		rem_ge = rem_c >= abmc_pkg::LN2_Q28;
		r_c    = rem_ge ? 28'(rem_c - abmc_pkg::LN2_Q28) : rem_c[27:0];
		t_over = |mul_q[66:62];
		t_c    = t_over ? '1 : mul_q[61:30];
		// shift = 30 - k with k = q - 24
		sh_c      = 6'(abmc_pkg::KSH_BASE) - q_q;
		shifted_c = mul_q[63:0] >> sh_c;
		spot_over = |shifted_c[63:32];
		spot_new_c = spot_over ? '1 : shifted_c[31:0];
		diff_c    = {1'b0, spot_q[leg_q]} - {1'b0, strike_q};
		pay_zero  = ko_q[leg_q] || (spot_q[leg_q] <= strike_q);
		pay_sum_c = {1'b0, pay_q[0]} + {1'b0, pay_q[1]};
		pair_c    = pay_sum_c[32:1];
		sq_add_c  = {1'b0, sqsum_q} + {1'b0, mul_q[63:0]};
		path_nx   = path_q + 16'd1;
		paths_eff = (paths_q == '0) ? 16'd1 : paths_q;
		steps_eff = (steps_q == '0) ? 13'd1 :
			(steps_q > 13'(abmc_pkg::MAX_STEPS)) ? 13'(abmc_pkg::MAX_STEPS) : steps_q;
		step_nx   = step_q + 13'd1;
		qsq_c     = (|div_quo[95:64]) ? '1 : div_quo[63:0];
		d_c       = (sqsum_q > qsq_c) ? sqsum_q - qsq_c : '0;
		is_trial  = isr_q + isb_q;
		is_ge     = isv_q >= is_trial;
		isr_nx    = is_ge ? (isr_q >> 1) + isb_q : isr_q >> 1;
		acc_nx    = acc_q + {mul_q[31:0], 64'd0};
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				mul_a = 32'(rv_q);
				mul_b = 35'(gmag_c);
			end
			S_LEG: begin
				mul_a = 32'(abmc_pkg::LN2_RECIP);
				mul_b = 35'(xo_c);
			end
			S_K: begin
				mul_a = 32'(mul_q[abmc_pkg::LN2_RECIP_SH+5:abmc_pkg::LN2_RECIP_SH]);
				mul_b = 35'(abmc_pkg::LN2_Q28);
			end
			S_TA: begin
				mul_a = 32'(term_q);
				mul_b = 35'(r30_q);
			end
			S_TB: begin
				mul_a = 32'(mul_q[59:30]);
				mul_b = abmc_pkg::taylor_recip(i_q);
			end
			S_D1: begin
				mul_a = spot_q[leg_q];
				mul_b = 35'(drift_q);
			end
			S_D2: begin
				mul_a = t_c;
				mul_b = 35'(m_q);
			end
			S_P: begin
				mul_a = diff_c[31:0];
				mul_b = 35'(disc_q);
			end
			S_PAIR: begin
				mul_a = pair_c;
				mul_b = 35'(pair_c);
			end
			S_MEAN: begin
				mul_a = sum_q[31:0];
				mul_b = 35'(sum_q[31:0]);
			end
			S_Q1: begin
				mul_a = 32'(sum_q[47:32]);
				mul_b = 35'(sum_q[31:0]);
			end
			S_Q2: begin
				mul_a = 32'(sum_q[47:32]);
				mul_b = 35'(sum_q[47:32]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= abmc_pkg::MUL_P_W'(mul_a) * abmc_pkg::MUL_P_W'(mul_b);
	end

	abmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num_q),
		.den    (path_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_spot_q <= abmc_pkg::RST_START_SPOT;
			strike_q     <= abmc_pkg::RST_STRIKE;
			barrier_q    <= abmc_pkg::RST_BARRIER;
			drift_q      <= abmc_pkg::RST_DRIFT;
			rv_q         <= abmc_pkg::RST_ROOT_VAR;
			disc_q       <= abmc_pkg::RST_DISCOUNT;
			steps_q      <= abmc_pkg::RST_STEPS;
			paths_q      <= abmc_pkg::RST_PATHS;
			ko_q[0]      <= 1'b0;
			ko_q[1]      <= 1'b0;
			leg_q        <= 1'b0;
			step_q       <= '0;
			path_q       <= '0;
			sum_q        <= '0;
			sqsum_q      <= '0;
			sat_q        <= 1'b0;
			last_q       <= 1'b0;
			div_go_q     <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (results.ready) begin
				out_vld_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				case (cfg_index)
					abmc_pkg::CFG_START_SPOT: start_spot_q <= cfg_data;
					abmc_pkg::CFG_STRIKE:     strike_q     <= cfg_data;
					abmc_pkg::CFG_BARRIER:    barrier_q    <= cfg_data;
					abmc_pkg::CFG_DRIFT:      drift_q      <= cfg_data;
					abmc_pkg::CFG_ROOT_VAR:   rv_q         <= cfg_data[16:0];
					abmc_pkg::CFG_DISCOUNT:   disc_q       <= cfg_data[30:0];
					abmc_pkg::CFG_STEPS:      steps_q      <= cfg_data[12:0];
					abmc_pkg::CFG_PATHS:      paths_q      <= cfg_data[15:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						g_neg_q <= samples.gauss_sample[15];
						leg_q   <= 1'b0;
						if (step_q == '0) begin
							spot_q[0] <= start_spot_q;
							spot_q[1] <= start_spot_q;
							ko_q[0]   <= 1'b0;
							ko_q[1]   <= 1'b0;
						end
						state_q <= S_X;
					end
				end
				S_X: begin
					xmag_q  <= mul_q[32:0];
					state_q <= S_LEG;
				end
				S_LEG: begin
					xo_q <= xo_c;
					if (ko_q[leg_q]) begin
						// frozen leg: no update
						if (leg_q) begin
							state_q <= S_STEP;
						end else begin
							leg_q <= 1'b1;
						end
					end else begin
						state_q <= S_K;
					end
				end
				S_K: begin
					q_q     <= mul_q[abmc_pkg::LN2_RECIP_SH+5:abmc_pkg::LN2_RECIP_SH];
					state_q <= S_R;
				end
				S_R: begin
					// reciprocal estimate is at most one low
					if (rem_ge) begin
						q_q <= q_q + 6'd1;
					end
					r30_q   <= {r_c, 2'b00};
					term_q  <= 31'(abmc_pkg::ONE_Q30);
					m_q     <= abmc_pkg::ONE_Q30;
					i_q     <= 4'd1;
					state_q <= S_TA;
				end
				S_TA: begin
					state_q <= S_TB;
				end
				S_TB: begin
					state_q <= S_TC;
				end
				S_TC: begin
					term_q <= mul_q[64:34];
					m_q    <= m_q + 32'(mul_q[64:34]);
					if (i_q == 4'(abmc_pkg::TAYLOR_TERMS)) begin
						state_q <= S_D1;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_TA;
					end
				end
				S_D1: begin
					state_q <= S_D2;
				end
				S_D2: begin
					if (t_over) begin
						sat_q <= 1'b1;
					end
					state_q <= S_M;
				end
				S_M: begin
					spot_q[leg_q] <= spot_new_c;
					if (spot_over) begin
						sat_q <= 1'b1;
					end
					if (spot_new_c > barrier_q) begin
						ko_q[leg_q] <= 1'b1;
					end
					if (leg_q) begin
						state_q <= S_STEP;
					end else begin
						leg_q   <= 1'b1;
						state_q <= S_LEG;
					end
				end
				S_STEP: begin
					if (step_nx >= steps_eff) begin
						step_q  <= '0;
						leg_q   <= 1'b0;
						state_q <= S_P;
					end else begin
						step_q  <= step_nx;
						state_q <= S_IDLE;
					end
				end
				S_P: begin
					if (pay_zero) begin
						pay_q[leg_q] <= '0;
						if (leg_q) begin
							state_q <= S_PAIR;
						end else begin
							leg_q <= 1'b1;
						end
					end else begin
						state_q <= S_P2;
					end
				end
				S_P2: begin
					if (|mul_q[66:62]) begin
						pay_q[leg_q] <= '1;
						sat_q        <= 1'b1;
					end else begin
						pay_q[leg_q] <= mul_q[61:30];
					end
					if (leg_q) begin
						state_q <= S_PAIR;
					end else begin
						leg_q   <= 1'b1;
						state_q <= S_P;
					end
				end
				S_PAIR: begin
					pair_q  <= pair_c;
					sum_q   <= sum_q + abmc_pkg::SUM_W'(pair_c);
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (sq_add_c[64]) begin
						sqsum_q <= '1;
						sat_q   <= 1'b1;
					end else begin
						sqsum_q <= sq_add_c[63:0];
					end
					path_q <= path_nx;
					mean_q <= '0;
					se_q   <= '0;
					if (path_nx >= paths_eff) begin
						last_q    <= 1'b1;
						div_go_q  <= 1'b1;
						div_num_q <= abmc_pkg::DIV_W'(sum_q);
						state_q   <= S_MEAN;
					end else begin
						last_q  <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_MEAN: begin
					if (div_done) begin
						mean_q  <= div_quo[31:0];
						state_q <= S_Q1;
					end
				end
				S_Q1: begin
					acc_q   <= abmc_pkg::DIV_W'(mul_q[63:0]);
					state_q <= S_Q2;
				end
				S_Q2: begin
					// cross term counted twice
					acc_q   <= acc_q + {14'd0, mul_q[48:0], 33'd0};
					state_q <= S_Q3;
				end
				S_Q3: begin
					div_go_q  <= 1'b1;
					div_num_q <= acc_nx;
					state_q   <= S_QD;
				end
				S_QD: begin
					if (div_done) begin
						isv_q   <= d_c;
						isr_q   <= '0;
						isb_q   <= 64'h4000_0000_0000_0000;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (is_ge) begin
						isv_q <= isv_q - is_trial;
					end
					isr_q <= isr_nx;
					isb_q <= isb_q >> 2;
					if (isb_q == 64'd1) begin
						div_go_q  <= 1'b1;
						div_num_q <= abmc_pkg::DIV_W'(isr_nx);
						state_q   <= S_SED;
					end
				end
				S_SED: begin
					if (div_done) begin
						se_q    <= div_quo[31:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_vld_q || results.ready) begin
						out_vld_q  <= 1'b1;
						out_pair_q <= pair_q;
						out_sum_q  <= last_q;
						out_mean_q <= mean_q;
						out_se_q   <= se_q;
						out_sat_q  <= sat_q;
						if (last_q) begin
							path_q  <= '0;
							sum_q   <= '0;
							sqsum_q <= '0;
							sat_q   <= 1'b0;
							last_q  <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign samples.ready         = (state_q == S_IDLE);
	assign results.valid         = out_vld_q;
	assign results.pair_payoff   = out_pair_q;
	assign results.summary_valid = out_sum_q;
	assign results.price_mean    = out_mean_q;
	assign results.std_err       = out_se_q;
	assign results.sum_saturated = out_sat_q;

endmodule

### bench/antithetic_barrier_mc_pricer_tb.sv
module antithetic_barrier_mc_pricer_tb;

	typedef struct {
		logic [31:0] pair;
		logic        summ;
		logic [31:0] mean;
		logic [31:0] serr;
		logic        sat;
	} pricing_result_t;

	localparam longint LN2 = 186065280;
	localparam longint unsigned CAP32 = 64'hFFFF_FFFF;
	localparam longint unsigned CAP64 = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	abmc_pkg::cfg_idx_t cfg_index = abmc_pkg::CFG_START_SPOT;
	logic [abmc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	abmc_in_if smp();
	abmc_out_if res();

	antithetic_barrier_mc_pricer uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .samples(smp), .results(res)
	);

	always #2 clk = ~clk;

	// predictor state
	longint unsigned reg_val [8];
	longint unsigned spot_up, spot_dn, pay_sum, pay_sq_sum;
	bit out_up, out_dn, run_sat;
	int unsigned step_cnt, path_cnt;

	logic signed [abmc_pkg::SAMPLE_W-1:0] sample_q [$];
	pricing_result_t payoff_q [$];
	int unsigned n_taken, n_results, n_runs, n_errors;
	int unsigned send_gap, stall_left;
	bit beat_in, no_idle;

	function automatic longint unsigned clip32(longint unsigned v);
		if (v > CAP32) begin
			run_sat = 1'b1;
			return CAP32;
		end
		return v;
	endfunction

	function automatic longint unsigned step_spot(longint unsigned spot, longint x);
		longint k, r;
		longint unsigned r30, term, m, t;
		int sh;
		k = x / LN2;
		if (x % LN2 != 0 && x < 0)
			k--;
		r = x - k * LN2;
		r30 = longint'(r) << 2;
		term = 64'd1 << 30;
		m = term;
		for (int i = 1; i <= 13; i++) begin
			term = ((term * r30) >> 30) / i;
			m += term;
		end
		if (k > 23) k = 23;
		if (k < -33) k = -33;
		sh = int'(30 - k);
		t = clip32((spot * reg_val[abmc_pkg::CFG_DRIFT]) >> 30);
		return clip32((t * m) >> sh);
	endfunction

	function automatic longint unsigned leg_value(longint unsigned spot, bit out);
		if (out || spot <= reg_val[abmc_pkg::CFG_STRIKE])
			return 0;
		return clip32(((spot - reg_val[abmc_pkg::CFG_STRIKE]) *
			reg_val[abmc_pkg::CFG_DISCOUNT]) >> 30);
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		logic [127:0] acc, cand;
		acc = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = acc | (128'd1 << b);
			if (cand * cand <= v)
				acc = cand;
		end
		return acc[63:0];
	endfunction

	task automatic price_sample(input logic signed [abmc_pkg::SAMPLE_W-1:0] g);
		longint x;
		longint unsigned steps, paths, p1, p2, pair, sq, n, d;
		logic [127:0] q;
		pricing_result_t e;
		x = longint'(reg_val[abmc_pkg::CFG_ROOT_VAR]) * longint'(g);
		steps = reg_val[abmc_pkg::CFG_STEPS];
		paths = reg_val[abmc_pkg::CFG_PATHS];
		if (steps == 0) steps = 1;
		if (steps > abmc_pkg::MAX_STEPS) steps = abmc_pkg::MAX_STEPS;
		if (paths == 0) paths = 1;
		if (step_cnt == 0) begin
			spot_up = reg_val[abmc_pkg::CFG_START_SPOT];
			spot_dn = reg_val[abmc_pkg::CFG_START_SPOT];
			out_up = 0;
			out_dn = 0;
		end
		if (!out_up) spot_up = step_spot(spot_up, x);
		if (!out_dn) spot_dn = step_spot(spot_dn, -x);
		if (spot_up > reg_val[abmc_pkg::CFG_BARRIER]) out_up = 1;
		if (spot_dn > reg_val[abmc_pkg::CFG_BARRIER]) out_dn = 1;
		step_cnt++;
		if (step_cnt < steps)
			return;
		step_cnt = 0;
		p1 = leg_value(spot_up, out_up);
		p2 = leg_value(spot_dn, out_dn);
		pair = (p1 + p2) >> 1;
		pay_sum += pair;
		sq = pair * pair;
		if (pay_sq_sum > CAP64 - sq) begin
			pay_sq_sum = CAP64;
			run_sat = 1;
		end else begin
			pay_sq_sum += sq;
		end
		path_cnt++;
		e.pair = pair[31:0];
		e.summ = path_cnt >= paths;
		e.mean = 0;
		e.serr = 0;
		if (e.summ) begin
			n = path_cnt;
			q = (128'(pay_sum) * 128'(pay_sum)) / n;
			if (q > 128'(CAP64)) q = 128'(CAP64);
			d = pay_sq_sum > q[63:0] ? pay_sq_sum - q[63:0] : 0;
			e.mean = 32'(pay_sum / n);
			e.serr = 32'(root64(d) / n);
		end
		e.sat = run_sat;
		if (e.summ) begin
			path_cnt = 0;
			pay_sum = 0;
			pay_sq_sum = 0;
			run_sat = 0;
		end
		payoff_q.push_back(e);
	endtask

	// sample driver and result back-pressure
	always @(negedge clk) begin
		logic nv;
		nv = smp.valid;
		if (beat_in) begin
			beat_in = 0;
			nv = 0;
			send_gap = no_idle ? 0 : $urandom_range(0, 11);
		end
		if (!nv) begin
			if (send_gap > 0)
				send_gap--;
			else if (sample_q.size() > 0) begin
				smp.gauss_sample <= sample_q.pop_front();
				nv = 1;
			end
		end
		smp.valid <= nv;
		if (stall_left > 0) begin
			res.ready <= 1'b0;
			stall_left--;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// monitor: check results first, then predict from the sample beat
	always @(posedge clk) begin
		pricing_result_t e;
		if (arst_n && res.valid && res.ready) begin
			n_results++;
			stall_left = no_idle ? 0 : $urandom_range(0, 11);
			if (payoff_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result beat, pair_payoff=%0d", res.pair_payoff);
			end else begin
				e = payoff_q.pop_front();
				if (e.summ) n_runs++;
				if (e.pair !== res.pair_payoff || e.summ !== res.summary_valid ||
						e.mean !== res.price_mean || e.serr !== res.std_err ||
						e.sat !== res.sum_saturated) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"mismatch: exp pair=%0d summ=%0d mean=%0d se=%0d sat=%0d",
							" got %0d %0d %0d %0d %0d"},
							e.pair, e.summ, e.mean, e.serr, e.sat, res.pair_payoff,
							res.summary_valid, res.price_mean, res.std_err, res.sum_saturated);
				end
			end
		end
		if (arst_n && smp.valid && smp.ready) begin
			beat_in = 1;
			n_taken++;
			price_sample(smp.gauss_sample);
		end
	end

	task automatic write_reg(input abmc_pkg::cfg_idx_t idx, input longint unsigned v);
		longint unsigned mask [8] = '{CAP32, CAP32, CAP32, CAP32, 64'h1FFFF,
			64'h7FFF_FFFF, 64'h1FFF, 64'hFFFF};
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[31:0];
		reg_val[idx] = v & mask[idx];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (sample_q.size() > 0 || smp.valid || payoff_q.size() > 0);
		// last sample may still be in flight with nothing expected from it
		repeat (450) @(posedge clk);
	endtask

	function automatic logic signed [15:0] draw_sample(bit wide);
		int s;
		if (wide)
			return 16'($urandom_range(0, 65535));
		s = $urandom_range(0, 8191) + $urandom_range(0, 8191) + $urandom_range(0, 8191) - 12288;
		return 16'(s);
	endfunction

	task automatic push_random(input int n, input bit wide);
		for (int i = 0; i < n; i++)
			sample_q.push_back(draw_sample(wide));
	endtask

	task automatic random_setup();
		longint unsigned s0;
		s0 = longint'($urandom_range(40, 160)) << 16;
		write_reg(abmc_pkg::CFG_START_SPOT, $urandom_range(0, 7) == 0 ? $urandom() : s0);
		write_reg(abmc_pkg::CFG_STRIKE, $urandom_range(0, 7) == 0 ? $urandom() :
			s0 + $urandom_range(0, 40 << 16) - (20 << 16));
		write_reg(abmc_pkg::CFG_BARRIER, $urandom_range(0, 7) == 0 ? $urandom() :
			s0 + $urandom_range(0, 60 << 16));
		write_reg(abmc_pkg::CFG_DRIFT, $urandom_range(0, 7) == 0 ? $urandom() :
			(64'd1 << 30) + $urandom_range(0, 1 << 21) - (1 << 20));
		write_reg(abmc_pkg::CFG_ROOT_VAR, $urandom_range(0, 7) == 0 ?
			$urandom_range(0, 131071) : $urandom_range(0, 4000));
		write_reg(abmc_pkg::CFG_DISCOUNT, $urandom_range(0, 7) == 0 ?
			$urandom_range(0, 32'h7FFF_FFFF) : $urandom_range(32'h3000_0000, 32'h4000_0000));
		write_reg(abmc_pkg::CFG_STEPS, $urandom_range(1, 6));
		write_reg(abmc_pkg::CFG_PATHS, $urandom_range(1, 8));
	endtask

	initial begin
		int nsteps, npaths;
		smp.valid = 1'b0;
		smp.gauss_sample = '0;
		res.ready = 1'b0;
		reg_val = '{abmc_pkg::RST_START_SPOT, abmc_pkg::RST_STRIKE, abmc_pkg::RST_BARRIER,
			abmc_pkg::RST_DRIFT, abmc_pkg::RST_ROOT_VAR, abmc_pkg::RST_DISCOUNT,
			abmc_pkg::RST_STEPS, abmc_pkg::RST_PATHS};
		{step_cnt, path_cnt, pay_sum, pay_sq_sum, run_sat, out_up, out_dn} = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: sample extremes on one-step paths, then short multi-step paths
		write_reg(abmc_pkg::CFG_STEPS, 1);
		write_reg(abmc_pkg::CFG_PATHS, 5);
		sample_q = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1, 16'sd1};
		settle();
		write_reg(abmc_pkg::CFG_STEPS, 3);
		write_reg(abmc_pkg::CFG_PATHS, 2);
		sample_q = '{16'sd4096, -16'sd4096, 16'sd8192, 16'sd0, 16'sd0, 16'sd0};
		settle();

		// register extremes; zero counts behave as one
		write_reg(abmc_pkg::CFG_START_SPOT, CAP32);
		write_reg(abmc_pkg::CFG_STRIKE, 0);
		write_reg(abmc_pkg::CFG_BARRIER, CAP32);
		write_reg(abmc_pkg::CFG_DRIFT, CAP32);
		write_reg(abmc_pkg::CFG_ROOT_VAR, 131071);
		write_reg(abmc_pkg::CFG_DISCOUNT, 32'h7FFF_FFFF);
		write_reg(abmc_pkg::CFG_STEPS, 0);
		write_reg(abmc_pkg::CFG_PATHS, 0);
		sample_q = '{16'sd32767, -16'sd32768, 16'sd0};
		settle();
		write_reg(abmc_pkg::CFG_START_SPOT, 0);
		write_reg(abmc_pkg::CFG_BARRIER, 0);
		write_reg(abmc_pkg::CFG_DRIFT, 0);
		write_reg(abmc_pkg::CFG_ROOT_VAR, 0);
		write_reg(abmc_pkg::CFG_DISCOUNT, 0);
		write_reg(abmc_pkg::CFG_STRIKE, CAP32);
		sample_q = '{16'sd100, -16'sd100, 16'sd12000};
		settle();

		// over-range counts, then counts lowered mid-path and mid-run
		random_setup();
		write_reg(abmc_pkg::CFG_STEPS, 13'h1FFF);
		write_reg(abmc_pkg::CFG_PATHS, 16'hFFFF);
		push_random(20, 0);
		settle();
		write_reg(abmc_pkg::CFG_STEPS, 2);
		push_random(11, 0);
		settle();
		write_reg(abmc_pkg::CFG_PATHS, 2);
		push_random(2, 0);
		settle();

		while (n_taken < 550) begin
			no_idle = $urandom_range(0, 4) == 0;
			random_setup();
			nsteps = int'(reg_val[abmc_pkg::CFG_STEPS]);
			npaths = int'(reg_val[abmc_pkg::CFG_PATHS]);
			push_random(nsteps * npaths * $urandom_range(1, 2) + $urandom_range(0, 1),
				$urandom_range(0, 9) == 0);
			settle();
		end
		no_idle = 0;

		$display("%0d samples taken, %0d path results checked over %0d completed runs",
			n_taken, n_results, n_runs);
		if (n_errors == 0 && payoff_q.size() == 0)
			$display("antithetic_barrier_mc_pricer regression: pass");
		else
			$display("antithetic_barrier_mc_pricer regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("timeout with %0d results outstanding", payoff_q.size());
		$display("antithetic_barrier_mc_pricer regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/core/abmc_pkg.sv
rtl/core/abmc_if.sv
rtl/core/abmc_div.sv
rtl/core/antithetic_barrier_mc_pricer.sv
bench/antithetic_barrier_mc_pricer_tb.sv
